### sv/tcw_pkg.sv
// Shared constants, field widths and controller/datapath interface types of the text console.
`default_nettype none

package tcw_pkg;

    // Default geometry of the character store.
    localparam int DEF_MAX_COLS = 128;
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_TAB_STOP = 4;

    // Fixed widths of the item fields and registers.
    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int CELL_ROW_W = 6;
    localparam int CELL_COL_W = 7;
    localparam int CUR_ROW_W  = 7;
    localparam int CUR_COL_W  = 8;
    localparam int LINES_W    = 16;
    localparam int CFG_COLS_W = 8;
    localparam int CFG_ROWS_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IDX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IDX = 1'b1;

    // Register reset values.
    localparam logic [CFG_COLS_W-1:0] COLS_RESET = 8'd80;
    localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = 7'd24;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Character codes with special meaning.
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;       // latch the item fields, restart the sweep counter
        logic home;         // cursor to row 0, column 0
        logic sweep_space;  // write a space at the sweep address and advance
        logic wrap;         // apply the deferred wrap
        logic put_char;     // store a printable character and advance the cursor
        logic scroll_step;  // one cell of the scroll copy or bottom-row blanking
        logic scroll_end;   // park the cursor on the bottom row in use
        logic fill_step;    // blank one cell of a newline or tab span
        logic finish;       // the item's result goes out next cycle
        logic finish_read;  // the result carries the cell that was read
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_last;   // sweep counter is at the last cell of the store
        logic scroll_last;  // sweep counter is at the last cell of the bottom row
        logic need_scroll;  // cursor row after wrap lies below the area in use
        logic is_plain;     // latched character is neither newline nor tab
        logic fill_last;    // current span cell is the last one
    } sts_t;

endpackage

`default_nettype wire

### sv/text_console_writer.sv
// Top level of the text console: character-cell store with cursor, wrap and scroll.
// An item is accepted while busy is low and its result is shown on done. A read or an unused
// operation finishes in the read state and a printable character in the execute state. Newline
// and tab add the blanking of their span cell by cell, a scroll adds a pass over every cell of
// the rows in use, and clear sweeps every cell of the store, all through the single memory write port.
// After reset a clearing pass over every cell of the store keeps busy high; results cannot stall.
`default_nettype none

module text_console_writer #(
    parameter int MAX_COLS = tcw_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tcw_pkg::DEF_MAX_ROWS,
    parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [tcw_pkg::OP_W-1:0]       operation,
    input  wire logic [tcw_pkg::CHAR_W-1:0]     char_code,
    input  wire logic [tcw_pkg::CELL_ROW_W-1:0] cell_row,
    input  wire logic [tcw_pkg::CELL_COL_W-1:0] cell_col,
    input  wire logic                         cfg_we,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                              done,
    output logic [tcw_pkg::CHAR_W-1:0]          cell_char,
    output logic [tcw_pkg::CUR_ROW_W-1:0]       cursor_row,
    output logic [tcw_pkg::CUR_COL_W-1:0]       cursor_col,
    output logic [tcw_pkg::LINES_W-1:0]         lines_written
);
    import tcw_pkg::*;

    // The controller walks each write item through its steps: an execute step that applies the
    // deferred wrap, an optional scroll that copies every row in use one row up through the
    // registered read port and then blanks the bottom row, and a span loop that blanks the
    // cells of a newline or tab one per cycle.
    cmd_t cmd;
    sts_t sts;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    // The datapath owns the character memory, the cursor and the two geometry registers.
    // Read items go through the same registered read port as the scroll.
    tcw_dpath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .operation     (operation),
        .char_code     (char_code),
        .cell_row      (cell_row),
        .cell_col      (cell_col),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cell_char     (cell_char),
        .cursor_row    (cursor_row),
        .cursor_col    (cursor_col),
        .lines_written (lines_written)
    );

endmodule

`default_nettype wire

### sv/tcw_ctrl.sv
// Controller state machine of the text console: sequences sweeps, scrolls and spans.
`default_nettype none

module tcw_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [tcw_pkg::OP_W-1:0] operation,
    input  wire tcw_pkg::sts_t          sts,
    output tcw_pkg::cmd_t               cmd,
    output logic                        busy,
    output logic                        done
);
    import tcw_pkg::*;

    typedef enum logic [7:0] {
        ST_INIT   = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_EXEC   = 8'b0000_0100,
        ST_SCROLL = 8'b0000_1000,
        ST_DRAIN  = 8'b0001_0000,
        ST_FILL   = 8'b0010_0000,
        ST_READ   = 8'b0100_0000,
        ST_CLEAR  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_space = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    unique case (operation)
                        OP_WRITE: state_next = ST_EXEC;
                        OP_CLEAR:
                        begin
                            cmd.home   = 1'b1;
                            state_next = ST_CLEAR;
                        end
                        default:  state_next = ST_READ;
                    endcase
                end
            end
            ST_EXEC:
            begin
                cmd.wrap = 1'b1;
                if (sts.need_scroll)
                begin
                    state_next = ST_SCROLL;
                end
                else if (sts.is_plain)
                begin
                    cmd.put_char = 1'b1;
                    cmd.finish   = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end
            ST_SCROLL:
            begin
                cmd.scroll_step = 1'b1;
                if (sts.scroll_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.scroll_end = 1'b1;
                state_next     = ST_EXEC;
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                cmd.finish      = 1'b1;
                cmd.finish_read = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_CLEAR:
            begin
                cmd.sweep_space = 1'b1;
                if (sts.sweep_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.finish;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

### sv/tcw_dpath.sv
// Datapath of the text console: character memory, cursor, line count and registers.
`default_nettype none

module tcw_dpath #(
    parameter int MAX_COLS = tcw_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tcw_pkg::DEF_MAX_ROWS,
    parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tcw_pkg::cmd_t                cmd,
    output tcw_pkg::sts_t                     sts,
    input  wire logic [tcw_pkg::OP_W-1:0]       operation,
    input  wire logic [tcw_pkg::CHAR_W-1:0]     char_code,
    input  wire logic [tcw_pkg::CELL_ROW_W-1:0] cell_row,
    input  wire logic [tcw_pkg::CELL_COL_W-1:0] cell_col,
    input  wire logic                         cfg_we,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [tcw_pkg::CHAR_W-1:0]          cell_char,
    output logic [tcw_pkg::CUR_ROW_W-1:0]       cursor_row,
    output logic [tcw_pkg::CUR_COL_W-1:0]       cursor_col,
    output logic [tcw_pkg::LINES_W-1:0]         lines_written
);
    import tcw_pkg::*;

    localparam int NCELLS = MAX_ROWS * MAX_COLS;
    localparam int AW     = $clog2(NCELLS);
    localparam int CW     = $clog2(MAX_COLS + 1);
    localparam int RW     = $clog2(MAX_ROWS + 1);
    localparam int TW     = $clog2(TAB_STOP);

    // Character memory, one byte per cell, row-major with MAX_COLS cells per row.
    logic [CHAR_W-1:0] mem [NCELLS];
    logic [CHAR_W-1:0] rdata_reg;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [CHAR_W-1:0] wdata;

    logic [CFG_COLS_W-1:0] cols_cfg_reg;
    logic [CFG_ROWS_W-1:0] rows_cfg_reg;
    logic [CW-1:0]         w;
    logic [RW-1:0]         h;

    logic [RW-1:0]      row_reg, row_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [TW-1:0]      tmod_reg, tmod_next;
    logic [LINES_W-1:0] lines_reg, lines_next;
    logic [AW-1:0]      sweep_reg, sweep_next;
    logic               cp_valid_reg;
    logic [AW-1:0]      cp_addr_reg;
    logic               cp_blank_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               rd_ok_reg;
    logic [CHAR_W-1:0]  cell_char_reg;

    logic          wrap;
    logic [RW-1:0] row_eff;
    logic [CW-1:0] col_eff;
    logic [TW-1:0] tmod_eff;
    logic [TW-1:0] tmod_inc;
    logic [CW-1:0] col_inc;
    logic          is_nl;
    logic          is_tab;
    logic          blank_ph;
    logic [AW-1:0] port_addr;
    logic [AW-1:0] scroll_raddr;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
        return AW'(int'(r) * MAX_COLS + int'(c));
    endfunction

    function automatic logic [TW-1:0] tmod_step(input logic [TW-1:0] m);
        return (m == TW'(TAB_STOP - 1)) ? '0 : TW'(m + 1'b1);
    endfunction

    // Registers in use, with zero read as one and large values clamped.
    always_comb
    begin
        if (cols_cfg_reg == '0)
            w = CW'(1);
        else if (int'(cols_cfg_reg) > MAX_COLS)
            w = CW'(MAX_COLS);
        else
            w = CW'(cols_cfg_reg);

        if (rows_cfg_reg == '0)
            h = RW'(1);
        else if (int'(rows_cfg_reg) > MAX_ROWS)
            h = RW'(MAX_ROWS);
        else
            h = RW'(rows_cfg_reg);
    end

    assign wrap     = (col_reg >= w);
    assign row_eff  = wrap ? RW'(row_reg + 1'b1) : row_reg;
    assign col_eff  = wrap ? '0 : col_reg;
    assign tmod_eff = wrap ? '0 : tmod_reg;
    assign tmod_inc = tmod_step(tmod_reg);
    assign col_inc  = CW'(col_reg + 1'b1);
    assign is_nl    = (char_reg == CH_NEWLINE);
    assign is_tab   = (char_reg == CH_TAB);

    assign blank_ph     = (int'(sweep_reg) >= (int'(h) - 1) * MAX_COLS);
    assign scroll_raddr = blank_ph ? sweep_reg : AW'(int'(sweep_reg) + MAX_COLS);
    assign port_addr    = AW'(int'(cell_row) * MAX_COLS + int'(cell_col));
    assign raddr        = cmd.scroll_step ? scroll_raddr : port_addr;

    always_comb
    begin
        sts.sweep_last  = (int'(sweep_reg) == NCELLS - 1);
        sts.scroll_last = (int'(sweep_reg) == int'(h) * MAX_COLS - 1);
        sts.need_scroll = (row_eff >= h);
        sts.is_plain    = !is_nl && !is_tab;
        sts.fill_last   = (col_inc >= w) || (is_tab && (tmod_inc == '0));
    end

    // Cursor, tab phase and line count.
    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        tmod_next  = tmod_reg;
        lines_next = lines_reg;
        if (cmd.home)
        begin
            row_next  = '0;
            col_next  = '0;
            tmod_next = '0;
        end
        if (cmd.wrap)
        begin
            row_next  = row_eff;
            col_next  = col_eff;
            tmod_next = tmod_eff;
            if (wrap)
                lines_next = LINES_W'(lines_reg + 1'b1);
        end
        if (cmd.put_char)
        begin
            col_next  = CW'(col_eff + 1'b1);
            tmod_next = tmod_step(tmod_eff);
        end
        if (cmd.fill_step)
        begin
            if (sts.fill_last && is_nl)
            begin
                row_next   = RW'(row_reg + 1'b1);
                col_next   = '0;
                tmod_next  = '0;
                lines_next = LINES_W'(lines_reg + 1'b1);
            end
            else
            begin
                col_next  = col_inc;
                tmod_next = tmod_inc;
            end
        end
        if (cmd.scroll_end)
            row_next = RW'(h - 1'b1);
    end

    always_comb
    begin
        if (cmd.accept)
            sweep_next = '0;
        else if (cmd.sweep_space || cmd.scroll_step)
            sweep_next = AW'(sweep_reg + 1'b1);
        else
            sweep_next = sweep_reg;
    end

    // Single write port: sweeps, the delayed scroll copy, characters and spans.
    always_comb
    begin
        we    = 1'b0;
        waddr = sweep_reg;
        wdata = CH_SPACE;
        if (cmd.sweep_space)
        begin
            we = 1'b1;
        end
        else if (cp_valid_reg)
        begin
            we    = 1'b1;
            waddr = cp_addr_reg;
            wdata = cp_blank_reg ? CH_SPACE : rdata_reg;
        end
        else if (cmd.put_char)
        begin
            we    = 1'b1;
            waddr = cell_addr(row_eff, col_eff);
            wdata = char_reg;
        end
        else if (cmd.fill_step)
        begin
            we    = 1'b1;
            waddr = cell_addr(row_reg, col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        cp_addr_reg  <= sweep_reg;
        cp_blank_reg <= blank_ph;
        if (cmd.accept)
        begin
            char_reg  <= char_code;
            rd_ok_reg <= (operation == OP_READ) && (int'(cell_row) < int'(h))
                         && (int'(cell_col) < int'(w));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg  <= COLS_RESET;
            rows_cfg_reg  <= ROWS_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            tmod_reg      <= '0;
            lines_reg     <= '0;
            sweep_reg     <= '0;
            cp_valid_reg  <= 1'b0;
            cell_char_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_COLS_IDX: cols_cfg_reg <= cfg_data[CFG_COLS_W-1:0];
                    CFG_ROWS_IDX: rows_cfg_reg <= cfg_data[CFG_ROWS_W-1:0];
                endcase
            end
            row_reg      <= row_next;
            col_reg      <= col_next;
            tmod_reg     <= tmod_next;
            lines_reg    <= lines_next;
            sweep_reg    <= sweep_next;
            cp_valid_reg <= cmd.scroll_step;
            if (cmd.finish)
                cell_char_reg <= (cmd.finish_read && rd_ok_reg) ? rdata_reg : '0;
        end
    end

    assign cell_char     = cell_char_reg;
    assign cursor_row    = CUR_ROW_W'(row_reg);
    assign cursor_col    = CUR_COL_W'(col_reg);
    assign lines_written = lines_reg;

endmodule

`default_nettype wire

### sv/tcw_checker.sv
// Port-level checker of the text console and its bind to the top level.
`default_nettype none

module tcw_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic [tcw_pkg::OP_W-1:0]       operation,
    input wire logic                         done,
    input wire logic [tcw_pkg::CUR_ROW_W-1:0]  cursor_row,
    input wire logic [tcw_pkg::CUR_COL_W-1:0]  cursor_col,
    input wire logic [tcw_pkg::LINES_W-1:0]    lines_written
);
    import tcw_pkg::*;

    // A result is only ever shown while the block is ready for the next item.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // An accepted item keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // An accepted read goes through the read state and then shows its result on done.
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == OP_READ) |-> ##2 done)
        else $error("read result late");

    // With no item in flight the cursor and line count hold still.
    a_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> ($stable(cursor_row) && $stable(cursor_col)
                               && $stable(lines_written)))
        else $error("cursor changed while idle");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

`default_nettype wire
